FILE: rtl/hslrgb_pkg.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Field widths and stream packing constants shared by the converter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hslrgb_pkg;

    // Width of each input fraction field.
    localparam int IN_W = 13;

    // Width of one color component.
    localparam int COLOR_W = 8;

    // Largest color component value.
    localparam logic [COLOR_W-1:0] COLOR_MAX = {COLOR_W{1'b1}};

    // Three input fields packed, padded up to whole bytes.
    localparam int S_TDATA_W = ((3 * IN_W + 7) / 8) * 8;

    // Three color components packed.
    localparam int M_TDATA_W = 3 * COLOR_W;

endpackage

`default_nettype wire

FILE: rtl/hslrgb_front.sv
// ----------------------------------------------------------------------------
// HSL to RGB front stage
// Clamps the inputs, forms the saturation-lightness product, the grey byte
// and the hue ramp positions of the three channels.
// ----------------------------------------------------------------------------
`default_nettype none

module hslrgb_front #(
    parameter int FRAC_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [hslrgb_pkg::IN_W-1:0]        hue,
    input  logic [hslrgb_pkg::IN_W-1:0]        saturation,
    input  logic [hslrgb_pkg::IN_W-1:0]        lightness,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [FRAC_BITS:0]                 l_out,
    output logic [FRAC_BITS:0]                 s_out,
    output logic [2*FRAC_BITS:0]               p_out,
    output logic [FRAC_BITS:0]                 fr_out,
    output logic [FRAC_BITS:0]                 fg_out,
    output logic [FRAC_BITS:0]                 fb_out,
    output logic                               gray_out,
    output logic [hslrgb_pkg::COLOR_W-1:0]     gray_byte_out
);
    import hslrgb_pkg::*;

    localparam int LW   = FRAC_BITS + 1;
    localparam int PW   = 2 * FRAC_BITS + 1;
    localparam int CMPW = (IN_W > LW) ? IN_W : LW;
    localparam int TW   = FRAC_BITS + 4;
    localparam int GW   = LW + COLOR_W;

    localparam logic [CMPW-1:0] ONE_C   = CMPW'(1) << FRAC_BITS;
    localparam logic [TW-1:0]   T_ONE   = TW'(1) << FRAC_BITS;
    localparam logic [TW-1:0]   T_TWO   = TW'(2) << FRAC_BITS;
    localparam logic [TW-1:0]   T_THREE = TW'(3) << FRAC_BITS;
    localparam logic [TW-1:0]   T_FOUR  = TW'(4) << FRAC_BITS;
    localparam logic [TW-1:0]   T_SIX   = TW'(6) << FRAC_BITS;

    function automatic logic [LW-1:0] clamp_one(input logic [IN_W-1:0] v);
        logic [CMPW-1:0] w;
        w = CMPW'(v);
        if (w > ONE_C)
            w = ONE_C;
        return w[LW-1:0];
    endfunction

    // Position on the ramp as a weight of the mix difference:
    // rising edge, top plateau, falling edge, bottom.
    function automatic logic [LW-1:0] ramp_pos(input logic [TW-1:0] t);
        logic [TW-1:0] diff;
        logic [LW-1:0] f;
        diff = T_FOUR - t;
        if (t < T_ONE)
            f = t[LW-1:0];
        else if (t < T_THREE)
            f = T_ONE[LW-1:0];
        else if (t < T_FOUR)
            f = diff[LW-1:0];
        else
            f = '0;
        return f;
    endfunction

    logic [LW-1:0]        h_c, s_c, l_c;
    logic [2*LW-1:0]      prod;
    logic [TW-1:0]        h6, t_r_raw, t_r, t_b;
    logic [GW-1:0]        gray_w;
    logic [COLOR_W:0]     gray_sh;

    logic                 valid_reg;
    logic [LW-1:0]        l_reg, s_reg, l_next, s_next;
    logic [PW-1:0]        p_reg, p_next;
    logic [LW-1:0]        fr_reg, fg_reg, fb_reg, fr_next, fg_next, fb_next;
    logic                 gray_reg, gray_next;
    logic [COLOR_W-1:0]   gray_byte_reg, gray_byte_next;

    always_comb
    begin
        h_c = clamp_one(hue);
        s_c = clamp_one(saturation);
        l_c = clamp_one(lightness);

        prod   = {{LW{1'b0}}, s_c} * {{LW{1'b0}}, l_c};
        p_next = prod[PW-1:0];

        // Hue scaled by six, so a third of the circle is two units.
        h6      = (TW'(h_c) << 2) + (TW'(h_c) << 1);
        t_r_raw = h6 + T_TWO;
        t_r     = (t_r_raw > T_SIX) ? (t_r_raw - T_SIX) : t_r_raw;
        t_b     = (h6 < T_TWO) ? (h6 + T_FOUR) : (h6 - T_TWO);

        fr_next = ramp_pos(t_r);
        fg_next = ramp_pos(h6);
        fb_next = ramp_pos(t_b);

        gray_w  = (GW'(l_c) << COLOR_W) - GW'(l_c);
        gray_sh = gray_w[GW-1:FRAC_BITS];
        gray_byte_next = (gray_sh > {1'b0, COLOR_MAX}) ? COLOR_MAX
                                                      : gray_sh[COLOR_W-1:0];
        gray_next = (s_c == '0);
        l_next    = l_c;
        s_next    = s_c;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            l_reg         <= l_next;
            s_reg         <= s_next;
            p_reg         <= p_next;
            fr_reg        <= fr_next;
            fg_reg        <= fg_next;
            fb_reg        <= fb_next;
            gray_reg      <= gray_next;
            gray_byte_reg <= gray_byte_next;
        end
    end

    assign out_valid     = valid_reg;
    assign l_out         = l_reg;
    assign s_out         = s_reg;
    assign p_out         = p_reg;
    assign fr_out        = fr_reg;
    assign fg_out        = fg_reg;
    assign fb_out        = fb_reg;
    assign gray_out      = gray_reg;
    assign gray_byte_out = gray_byte_reg;

endmodule

`default_nettype wire

FILE: rtl/hslrgb_mix.sv
// ----------------------------------------------------------------------------
// HSL to RGB mix stage
// Forms the low mix level and the difference between the two mix levels.
// ----------------------------------------------------------------------------
`default_nettype none

module hslrgb_mix #(
    parameter int FRAC_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [FRAC_BITS:0]                 l_in,
    input  logic [FRAC_BITS:0]                 s_in,
    input  logic [2*FRAC_BITS:0]               p_in,
    input  logic [FRAC_BITS:0]                 fr_in,
    input  logic [FRAC_BITS:0]                 fg_in,
    input  logic [FRAC_BITS:0]                 fb_in,
    input  logic                               gray_in,
    input  logic [hslrgb_pkg::COLOR_W-1:0]     gray_byte_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2*FRAC_BITS:0]               lo_out,
    output logic [2*FRAC_BITS:0]               d_out,
    output logic [FRAC_BITS:0]                 fr_out,
    output logic [FRAC_BITS:0]                 fg_out,
    output logic [FRAC_BITS:0]                 fb_out,
    output logic                               gray_out,
    output logic [hslrgb_pkg::COLOR_W-1:0]     gray_byte_out
);
    import hslrgb_pkg::*;

    localparam int LW = FRAC_BITS + 1;
    localparam int VW = 2 * FRAC_BITS + 1;
    localparam int XW = 2 * FRAC_BITS + 2;

    logic              low_half;
    logic [XW-1:0]     v2_x, v1_x, d_x, ls_sum;

    logic              valid_reg;
    logic [VW-1:0]     lo_reg, d_reg, lo_next, d_next;
    logic [LW-1:0]     fr_reg, fg_reg, fb_reg;
    logic              gray_reg;
    logic [COLOR_W-1:0] gray_byte_reg;

    always_comb
    begin
        // Lightness below one half when neither the one bit nor the half bit is set.
        low_half = !l_in[FRAC_BITS] && !l_in[FRAC_BITS-1];
        ls_sum   = XW'(l_in) + XW'(s_in);
        if (low_half)
        begin
            v2_x = (XW'(l_in) << FRAC_BITS) + XW'(p_in);
            d_x  = XW'(p_in) << 1;
        end
        else
        begin
            v2_x = (ls_sum << FRAC_BITS) - XW'(p_in);
            d_x  = ((XW'(s_in) << FRAC_BITS) - XW'(p_in)) << 1;
        end
        v1_x    = (XW'(l_in) << (FRAC_BITS + 1)) - v2_x;
        lo_next = v1_x[VW-1:0];
        d_next  = d_x[VW-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            lo_reg        <= lo_next;
            d_reg         <= d_next;
            fr_reg        <= fr_in;
            fg_reg        <= fg_in;
            fb_reg        <= fb_in;
            gray_reg      <= gray_in;
            gray_byte_reg <= gray_byte_in;
        end
    end

    assign out_valid     = valid_reg;
    assign lo_out        = lo_reg;
    assign d_out         = d_reg;
    assign fr_out        = fr_reg;
    assign fg_out        = fg_reg;
    assign fb_out        = fb_reg;
    assign gray_out      = gray_reg;
    assign gray_byte_out = gray_byte_reg;

endmodule

`default_nettype wire

FILE: rtl/hslrgb_ramp.sv
// ----------------------------------------------------------------------------
// HSL to RGB ramp stages
// Weights the mix difference by each channel's ramp position, then adds the
// low mix level, giving each channel's value at cube scale.
// ----------------------------------------------------------------------------
`default_nettype none

module hslrgb_ramp #(
    parameter int FRAC_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2*FRAC_BITS:0]               lo_in,
    input  logic [2*FRAC_BITS:0]               d_in,
    input  logic [FRAC_BITS:0]                 fr_in,
    input  logic [FRAC_BITS:0]                 fg_in,
    input  logic [FRAC_BITS:0]                 fb_in,
    input  logic                               gray_in,
    input  logic [hslrgb_pkg::COLOR_W-1:0]     gray_byte_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [3*FRAC_BITS:0]               cr_out,
    output logic [3*FRAC_BITS:0]               cg_out,
    output logic [3*FRAC_BITS:0]               cb_out,
    output logic                               gray_out,
    output logic [hslrgb_pkg::COLOR_W-1:0]     gray_byte_out
);
    import hslrgb_pkg::*;

    localparam int VW = 2 * FRAC_BITS + 1;
    localparam int MW = 3 * FRAC_BITS + 2;
    localparam int CW = 3 * FRAC_BITS + 1;

    // Multiply stage.
    logic               mul_valid_reg, mul_ready;
    logic [MW-1:0]      pr_reg, pg_reg, pb_reg, pr_next, pg_next, pb_next;
    logic [VW-1:0]      lo_reg;
    logic               mul_gray_reg;
    logic [COLOR_W-1:0] mul_gray_byte_reg;

    // Sum stage.
    logic               sum_valid_reg, sum_ready;
    logic [MW-1:0]      lo_sh, sr_x, sg_x, sb_x;
    logic [CW-1:0]      cr_reg, cg_reg, cb_reg, cr_next, cg_next, cb_next;
    logic               sum_gray_reg;
    logic [COLOR_W-1:0] sum_gray_byte_reg;

    always_comb
    begin
        pr_next = MW'(d_in) * MW'(fr_in);
        pg_next = MW'(d_in) * MW'(fg_in);
        pb_next = MW'(d_in) * MW'(fb_in);
    end

    always_comb
    begin
        lo_sh   = MW'(lo_reg) << FRAC_BITS;
        sr_x    = lo_sh + pr_reg;
        sg_x    = lo_sh + pg_reg;
        sb_x    = lo_sh + pb_reg;
        cr_next = sr_x[CW-1:0];
        cg_next = sg_x[CW-1:0];
        cb_next = sb_x[CW-1:0];
    end

    assign sum_ready = !sum_valid_reg || out_ready;
    assign mul_ready = !mul_valid_reg || sum_ready;
    assign in_ready  = mul_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_ready)
                mul_valid_reg <= in_valid;
            if (sum_ready)
                sum_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && mul_ready)
        begin
            pr_reg            <= pr_next;
            pg_reg            <= pg_next;
            pb_reg            <= pb_next;
            lo_reg            <= lo_in;
            mul_gray_reg      <= gray_in;
            mul_gray_byte_reg <= gray_byte_in;
        end
        if (mul_valid_reg && sum_ready)
        begin
            cr_reg            <= cr_next;
            cg_reg            <= cg_next;
            cb_reg            <= cb_next;
            sum_gray_reg      <= mul_gray_reg;
            sum_gray_byte_reg <= mul_gray_byte_reg;
        end
    end

    assign out_valid     = sum_valid_reg;
    assign cr_out        = cr_reg;
    assign cg_out        = cg_reg;
    assign cb_out        = cb_reg;
    assign gray_out      = sum_gray_reg;
    assign gray_byte_out = sum_gray_byte_reg;

endmodule

`default_nettype wire

FILE: rtl/hslrgb_out.sv
// ----------------------------------------------------------------------------
// HSL to RGB output stage
// Scales each channel by 255, truncates and saturates it to a byte, selects
// grey for zero saturation and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hslrgb_out #(
    parameter int FRAC_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [3*FRAC_BITS:0]               cr_in,
    input  logic [3*FRAC_BITS:0]               cg_in,
    input  logic [3*FRAC_BITS:0]               cb_in,
    input  logic                               gray_in,
    input  logic [hslrgb_pkg::COLOR_W-1:0]     gray_byte_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [hslrgb_pkg::COLOR_W-1:0]     red,
    output logic [hslrgb_pkg::COLOR_W-1:0]     green,
    output logic [hslrgb_pkg::COLOR_W-1:0]     blue
);
    import hslrgb_pkg::*;

    localparam int CW = 3 * FRAC_BITS + 1;
    localparam int BW = CW + COLOR_W;

    function automatic logic [COLOR_W-1:0] to_byte(input logic [CW-1:0] c);
        logic [BW-1:0]    scaled;
        logic [COLOR_W:0] top;
        scaled = (BW'(c) << COLOR_W) - BW'(c);
        top    = scaled[BW-1:3*FRAC_BITS];
        return (top > {1'b0, COLOR_MAX}) ? COLOR_MAX : top[COLOR_W-1:0];
    endfunction

    logic               valid_reg;
    logic [COLOR_W-1:0] red_reg, green_reg, blue_reg;
    logic [COLOR_W-1:0] red_next, green_next, blue_next;

    always_comb
    begin
        if (gray_in)
        begin
            red_next   = gray_byte_in;
            green_next = gray_byte_in;
            blue_next  = gray_byte_in;
        end
        else
        begin
            red_next   = to_byte(cr_in);
            green_next = to_byte(cg_in);
            blue_next  = to_byte(cb_in);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

`default_nettype wire

FILE: rtl/hsl_to_rgb_converter_core.sv
// An accepted beat passes the front, mix, multiply, sum and output registers.
// Throughput: one pixel per clock; every stage advances on its own handshake.
// The rate is set by the five-stage pipeline, whose deepest stage holds the
// three ramp multipliers. A stalled output lets earlier stages fill up.
// Reset clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// HSL to RGB converter core
// Converts one pixel per beat from hue, saturation and lightness fractions to
// 8-bit red, green and blue by the standard HSL rule, in fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_to_rgb_converter_core #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // hue [12:0], saturation [25:13], lightness [38:26], zero pad above
    input  logic [hslrgb_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // red [7:0], green [15:8], blue [23:16]
    output logic [hslrgb_pkg::M_TDATA_W-1:0]     m_tdata
);
    import hslrgb_pkg::*;

    localparam int LW = FRAC_BITS + 1;
    localparam int VW = 2 * FRAC_BITS + 1;
    localparam int CW = 3 * FRAC_BITS + 1;

    logic [IN_W-1:0]    hue, saturation, lightness;

    logic               fr_valid, fr_ready;
    logic [LW-1:0]      fr_l, fr_s, fr_fr, fr_fg, fr_fb;
    logic [VW-1:0]      fr_p;
    logic               fr_gray;
    logic [COLOR_W-1:0] fr_gray_byte;

    logic               mx_valid, mx_ready;
    logic [VW-1:0]      mx_lo, mx_d;
    logic [LW-1:0]      mx_fr, mx_fg, mx_fb;
    logic               mx_gray;
    logic [COLOR_W-1:0] mx_gray_byte;

    logic               rp_valid, rp_ready;
    logic [CW-1:0]      rp_cr, rp_cg, rp_cb;
    logic               rp_gray;
    logic [COLOR_W-1:0] rp_gray_byte;

    logic               ot_ready;
    logic [COLOR_W-1:0] red, green, blue;

    assign hue        = s_tdata[IN_W-1:0];
    assign saturation = s_tdata[2*IN_W-1:IN_W];
    assign lightness  = s_tdata[3*IN_W-1:2*IN_W];

    hslrgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .hue           (hue),
        .saturation    (saturation),
        .lightness     (lightness),
        .out_valid     (fr_valid),
        .out_ready     (fr_ready),
        .l_out         (fr_l),
        .s_out         (fr_s),
        .p_out         (fr_p),
        .fr_out        (fr_fr),
        .fg_out        (fr_fg),
        .fb_out        (fr_fb),
        .gray_out      (fr_gray),
        .gray_byte_out (fr_gray_byte)
    );

    hslrgb_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (fr_valid),
        .in_ready      (fr_ready),
        .l_in          (fr_l),
        .s_in          (fr_s),
        .p_in          (fr_p),
        .fr_in         (fr_fr),
        .fg_in         (fr_fg),
        .fb_in         (fr_fb),
        .gray_in       (fr_gray),
        .gray_byte_in  (fr_gray_byte),
        .out_valid     (mx_valid),
        .out_ready     (mx_ready),
        .lo_out        (mx_lo),
        .d_out         (mx_d),
        .fr_out        (mx_fr),
        .fg_out        (mx_fg),
        .fb_out        (mx_fb),
        .gray_out      (mx_gray),
        .gray_byte_out (mx_gray_byte)
    );

    hslrgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (mx_valid),
        .in_ready      (mx_ready),
        .lo_in         (mx_lo),
        .d_in          (mx_d),
        .fr_in         (mx_fr),
        .fg_in         (mx_fg),
        .fb_in         (mx_fb),
        .gray_in       (mx_gray),
        .gray_byte_in  (mx_gray_byte),
        .out_valid     (rp_valid),
        .out_ready     (rp_ready),
        .cr_out        (rp_cr),
        .cg_out        (rp_cg),
        .cb_out        (rp_cb),
        .gray_out      (rp_gray),
        .gray_byte_out (rp_gray_byte)
    );

    hslrgb_out #(.FRAC_BITS(FRAC_BITS)) u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (rp_valid),
        .in_ready     (ot_ready),
        .cr_in        (rp_cr),
        .cg_in        (rp_cg),
        .cb_in        (rp_cb),
        .gray_in      (rp_gray),
        .gray_byte_in (rp_gray_byte),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

    assign rp_ready = ot_ready;
    assign m_tdata  = {blue, green, red};

    // An empty output register means every stage can take a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output register is empty");

    // An accepted beat always lands in the front stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> fr_valid)
        else $error("accepted beat missing from the front stage");

    // A beat leaving the ramp stages always reaches the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rp_valid && ot_ready) |=> m_tvalid)
        else $error("beat lost between ramp and output stages");

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSL to RGB converter core testbench
// Streams pixels through the converter with random gaps on the input side and
// random stalls on the output side. Each accepted pixel is converted in the
// bench by an exact fixed-point HSL rule. Every output beat is then compared,
// component by component, with the oldest pending prediction.
// ----------------------------------------------------------------------------

module tb;

    import hslrgb_pkg::*;

    localparam int     FRAC       = 12;
    localparam longint ONE        = longint'(1) << FRAC;
    localparam int     IDLE_LIMIT = 2000;
    localparam int     TAIL_WAIT  = 20;

    typedef struct packed {
        logic [IN_W-1:0] hue;
        logic [IN_W-1:0] sat;
        logic [IN_W-1:0] light;
        logic [4:0]      gap;
        logic            drain;
    } hsl_px_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_px_t;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    hsl_px_t pixel_pending[$];
    rgb_px_t rgb_expected[$];

    hsl_px_t drv_cur;
    hsl_px_t drv_on_bus;
    bit      drv_hold;
    bit      drv_have;
    int      drv_wait;
    int      mon_stall;
    bit      mon_ready;
    int      idle_cycles;
    bit      timed_out;

    int px_sent;
    int px_checked;
    int rgb_mismatches;
    int grey_cnt;
    int above_one_cnt;
    int stall_cycles;

    hsl_to_rgb_converter_core #(
        .FRAC_BITS (FRAC)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Fixed-point HSL rule. Hue is carried as 6*hue, mix levels at scale
    // ONE^2 and ramp values at scale ONE^3, so only the final scaling rounds.
    // ------------------------------------------------------------------------
    function automatic longint frac_clamp(logic [IN_W-1:0] v);
        return (v > ONE) ? ONE : longint'(v);
    endfunction

    function automatic longint hue_ramp(longint lo, longint hi, longint t);
        longint d;
        d = hi - lo;
        if (t < 0)
            t += 6 * ONE;
        // An argument of exactly one full turn is kept as it is.
        if (t > 6 * ONE)
            t -= 6 * ONE;
        if (t < ONE)
            return lo * ONE + d * t;
        if (t < 3 * ONE)
            return hi * ONE;
        if (t < 4 * ONE)
            return lo * ONE + d * (4 * ONE - t);
        return lo * ONE;
    endfunction

    function automatic logic [COLOR_W-1:0] level_to_byte(longint c, int shift);
        longint v;
        v = (255 * c) >>> shift;
        return (v > 255) ? COLOR_MAX : v[COLOR_W-1:0];
    endfunction

    function automatic rgb_px_t hsl_pixel_rgb(hsl_px_t px);
        longint  h, s, l, mix_lo, mix_hi, th;
        rgb_px_t rgb;
        h = frac_clamp(px.hue);
        s = frac_clamp(px.sat);
        l = frac_clamp(px.light);
        if (s == 0)
        begin
            rgb.red   = level_to_byte(l, FRAC);
            rgb.green = rgb.red;
            rgb.blue  = rgb.red;
            return rgb;
        end
        if (2 * l < ONE)
            mix_hi = l * (ONE + s);
        else
            mix_hi = (l + s) * ONE - s * l;
        mix_lo = 2 * l * ONE - mix_hi;
        th = 6 * h;
        rgb.red   = level_to_byte(hue_ramp(mix_lo, mix_hi, th + 2 * ONE), 3 * FRAC);
        rgb.green = level_to_byte(hue_ramp(mix_lo, mix_hi, th), 3 * FRAC);
        rgb.blue  = level_to_byte(hue_ramp(mix_lo, mix_hi, th - 2 * ONE), 3 * FRAC);
        return rgb;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [IN_W-1:0] rand_frac();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return '0;
        if (pick < 10)
            return IN_W'(ONE);
        if (pick < 18)
            return IN_W'($urandom_range(32'(ONE + 1), 32'((1 << IN_W) - 1)));
        return IN_W'($urandom_range(0, 32'(ONE)));
    endfunction

    task automatic add_px(int h, int s, int l, int gap, bit drain);
        hsl_px_t px;
        px.hue   = IN_W'(h);
        px.sat   = IN_W'(s);
        px.light = IN_W'(l);
        px.gap   = 5'(gap);
        px.drain = drain;
        if (px.sat == 0)
            grey_cnt++;
        if (px.hue > ONE || px.sat > ONE || px.light > ONE)
            above_one_cnt++;
        pixel_pending = {pixel_pending, px};
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents pending pixels, each after its own gap.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            drv_have = 1'b0;
            drv_wait = 0;
        end
        else
        begin
            drv_hold = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                rgb_expected = {rgb_expected, hsl_pixel_rgb(drv_on_bus)};
                px_sent++;
                drv_hold = 1'b0;
            end
            if (!drv_hold)
            begin
                if (!drv_have && pixel_pending.size() > 0)
                begin
                    drv_cur  = pixel_pending.pop_front();
                    drv_wait = drv_cur.gap;
                    drv_have = 1'b1;
                end
                if (drv_have)
                begin
                    if (drv_wait > 0)
                        drv_wait--;
                    else if (!drv_cur.drain || rgb_expected.size() == 0)
                    begin
                        drv_hold   = 1'b1;
                        drv_have   = 1'b0;
                        drv_on_bus = drv_cur;
                        s_tdata    <= {{(S_TDATA_W - 3 * IN_W){1'b0}},
                                       drv_cur.light, drv_cur.sat, drv_cur.hue};
                    end
                end
            end
            s_tvalid <= drv_hold;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each output beat and stalls at random after it.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            mon_stall = 0;
        end
        else
        begin
            if (m_tvalid && !m_tready)
                stall_cycles++;
            if (m_tvalid && m_tready)
            begin
                if (rgb_expected.size() == 0)
                begin
                    rgb_mismatches++;
                    if (rgb_mismatches <= 10)
                        $display("%0t: output beat %h with no pixel pending", $realtime,
                                 m_tdata);
                end
                else
                begin
                    rgb_px_t want;
                    want = rgb_expected.pop_front();
                    if (m_tdata[7:0] !== want.red || m_tdata[15:8] !== want.green ||
                        m_tdata[23:16] !== want.blue)
                    begin
                        rgb_mismatches++;
                        if (rgb_mismatches <= 10)
                            $display({"%0t: pixel %0d expected r=%0d g=%0d b=%0d,",
                                      " got r=%0d g=%0d b=%0d"},
                                     $realtime, px_checked, want.red, want.green,
                                     want.blue, m_tdata[7:0], m_tdata[15:8],
                                     m_tdata[23:16]);
                    end
                end
                px_checked++;
                // Every fourth block of a hundred beats runs with no stalls.
                mon_stall = ((px_checked / 100) % 4 == 3) ? 0 : $urandom_range(0, 15);
            end
            mon_ready = (mon_stall == 0);
            if (mon_stall > 0)
                mon_stall--;
            m_tready <= mon_ready;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
                timed_out = 1'b1;
        end
    end

    initial
    begin
        int h;
        int s;
        int gap;
        int hue_marks[11] = '{0, 682, 683, 1365, 1366, 2048, 2730, 2731, 3413, 3414, 4096};

        // Directed pixels: grey, primaries, thirds of the circle, the
        // lightness half point, a full-turn hue and fields above one.
        add_px(0,    0,    0,    0, 1'b0);
        add_px(0,    0,    4096, 0, 1'b0);
        add_px(8191, 0,    8191, 3, 1'b0);
        add_px(0,    4096, 2048, 0, 1'b0);
        add_px(1365, 4096, 2048, 1, 1'b0);
        add_px(2731, 4096, 2048, 0, 1'b0);
        add_px(4096, 4096, 2048, 0, 1'b0);
        add_px(8191, 8191, 8191, 7, 1'b0);
        add_px(683,  4096, 2047, 0, 1'b0);
        add_px(682,  2048, 2048, 0, 1'b1);
        add_px(2048, 4096, 1024, 2, 1'b0);
        add_px(3413, 1,    4095, 0, 1'b0);
        add_px(3414, 4095, 1,    0, 1'b0);
        add_px(1366, 4096, 4096, 15, 1'b0);
        add_px(0,    4096, 0,    0, 1'b0);
        add_px(5000, 3000, 3000, 0, 1'b0);
        add_px(1000, 4097, 6000, 4, 1'b0);
        add_px(4095, 100,  2049, 0, 1'b0);
        add_px(2730, 8191, 0,    0, 1'b0);

        for (int i = 0; i < 1300; i++)
        begin
            h = ($urandom_range(0, 9) == 0) ? hue_marks[$urandom_range(0, 10)] : rand_frac();
            s = ($urandom_range(0, 11) == 0) ? 0 : rand_frac();
            gap = ((i / 100) % 4 == 1) ? 0 : $urandom_range(0, 15);
            add_px(h, s, rand_frac(), gap, (i == 400 || i == 900));
        end

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (!timed_out && (pixel_pending.size() > 0 || drv_have || s_tvalid ||
                              rgb_expected.size() > 0))
            @(posedge clk);
        if (!timed_out)
            repeat (TAIL_WAIT) @(posedge clk);

        if (rgb_expected.size() > 0)
            $display("%0d predicted pixels never came out", rgb_expected.size());
        $display("Converted %0d pixels: %0d grey, %0d with a field above one.",
                 px_checked, grey_cnt, above_one_cnt);
        $display("Input gaps and %0d output stall cycles; %0d mismatches.",
                 stall_cycles, rgb_mismatches);
        if (timed_out)
            $display("end of test: mismatches");
        else if (rgb_mismatches == 0 && rgb_expected.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
rtl/hslrgb_pkg.sv
rtl/hslrgb_front.sv
rtl/hslrgb_mix.sv
rtl/hslrgb_ramp.sv
rtl/hslrgb_out.sv
rtl/hsl_to_rgb_converter_core.sv
dv/tb.sv
